### sv/cvh_pkg.sv
// cvh_pkg: command and status bundles between the convex hull controller
// and datapath. no dependencies.
package cvh_pkg;

  typedef struct packed {
    logic cap;
    logic set_ovf;
    logic ins_rd;
    logic ins_shift;
    logic ins_place;
    logic h_init;
    logic h_latch;
    logic h_mul;
    logic h_pop;
    logic h_popa;
    logic h_push;
    logic h_nextj;
    logic e_rd0;
    logic e_out;
    logic clear;
  } cvh_cmd_t;

  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic less;
    logic i_one;
    logic fin;
    logic test_ok;
    logic left;
    logic top_ge3;
    logic j_last;
    logic phase_up;
    logic n_one;
    logic e_last;
  } cvh_stat_t;

endpackage

### sv/cvh_ram.sv
// cvh_ram: generic single-write, single-read ram with registered read.
// no dependencies.
module cvh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/cvh_datapath.sv
// cvh_datapath: point store, hull stack, counters and side test.
// depends on cvh_pkg and cvh_ram.
module cvh_datapath #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [COORD_BITS-1:0]  px,
  input  logic [COORD_BITS-1:0]  py,
  input  logic                   final_point,
  input  cvh_pkg::cvh_cmd_t      cmd,
  output cvh_pkg::cvh_stat_t     stat,
  output logic [COORD_BITS-1:0]  hx,
  output logic [COORD_BITS-1:0]  hy,
  output logic                   dropped
);

  localparam int C  = COORD_BITS;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SD = 2 * MAX_POINTS;
  localparam int SW = $clog2(SD);
  localparam int TW = $clog2(SD + 1);
  localparam int PW = 2 * C;

  logic [CW-1:0] cnt;
  logic          ovf;
  logic          fin;
  logic [C-1:0]  px_r, py_r;
  logic [AW-1:0] i;
  logic [AW-1:0] j;
  logic          phase;
  logic [TW-1:0] top;
  logic [TW-1:0] lend;
  logic [PW-1:0] pa, pb, pp;
  logic signed [2*C+1:0] pl, pr;
  logic [SW-1:0] k;

  logic [PW-1:0] prd, srd;
  logic          p_we;
  logic [AW-1:0] p_raddr;
  logic [PW-1:0] p_wdata;
  logic [SW-1:0] s_raddr;
  logic [TW-1:0] t_m3, limit, ecount;
  logic [SW-1:0] k1;
  logic signed [C:0] dy, dbx, dx, dby;

  assign p_we    = cmd.ins_shift | cmd.ins_place;
  assign p_wdata = cmd.ins_shift ? prd : {px_r, py_r};
  always_comb begin
    if (cmd.ins_shift) begin
      p_raddr = i - AW'(2);
    end else if (cmd.ins_rd) begin
      p_raddr = i - AW'(1);
    end else begin
      p_raddr = j;
    end
  end

  assign t_m3 = top - TW'(3);
  assign k1   = k + SW'(1);
  always_comb begin
    if (cmd.h_pop) begin
      s_raddr = t_m3[SW-1:0];
    end else if (cmd.e_out) begin
      s_raddr = k1;
    end else begin
      s_raddr = '0;
    end
  end

  cvh_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pts (
    .clk(clk), .we(p_we), .waddr(i), .wdata(p_wdata), .raddr(p_raddr), .rdata(prd)
  );

  cvh_ram #(.WIDTH(PW), .DEPTH(SD)) u_stack (
    .clk(clk), .we(cmd.h_push), .waddr(top[SW-1:0]), .wdata(pp), .raddr(s_raddr),
    .rdata(srd)
  );

  assign dy  = $signed({pp[C-1], pp[C-1:0]}) - $signed({pa[C-1], pa[C-1:0]});
  assign dbx = $signed({pb[PW-1], pb[PW-1:C]}) - $signed({pa[PW-1], pa[PW-1:C]});
  assign dx  = $signed({pp[PW-1], pp[PW-1:C]}) - $signed({pa[PW-1], pa[PW-1:C]});
  assign dby = $signed({pb[C-1], pb[C-1:0]}) - $signed({pa[C-1], pa[C-1:0]});

  assign limit  = phase ? (lend + TW'(1)) : TW'(2);
  assign ecount = stat.n_one ? TW'(1) : (top - TW'(1));

  always_comb begin
    stat.full     = (cnt == CW'(MAX_POINTS));
    stat.cnt_zero = (cnt == '0);
    stat.less     = ($signed(px_r) < $signed(prd[PW-1:C])) ||
                    ((px_r == prd[PW-1:C]) && ($signed(py_r) < $signed(prd[C-1:0])));
    stat.i_one    = (i == AW'(1));
    stat.fin      = fin;
    stat.test_ok  = (top >= limit);
    stat.left     = (pl >= pr);
    stat.top_ge3  = (top >= TW'(3));
    stat.j_last   = phase ? (j == '0) : (CW'(j) == (cnt - CW'(1)));
    stat.phase_up = phase;
    stat.n_one    = (cnt == CW'(1));
    stat.e_last   = (TW'(k) == (ecount - TW'(1)));
  end

  assign hx      = srd[PW-1:C];
  assign hy      = srd[C-1:0];
  assign dropped = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else begin
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.ins_place) begin
        cnt <= cnt + CW'(1);
      end
      if (cmd.clear) begin
        cnt <= '0;
        ovf <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      px_r <= px;
      py_r <= py;
      fin  <= final_point;
      i    <= cnt[AW-1:0];
    end
    if (cmd.ins_shift) begin
      i <= i - AW'(1);
    end
    if (cmd.h_init) begin
      top   <= '0;
      j     <= '0;
      phase <= 1'b0;
    end
    if (cmd.h_latch) begin
      pp <= prd;
    end
    if (cmd.h_mul) begin
      pl <= (2*C+2)'(dy) * (2*C+2)'(dbx);
      pr <= (2*C+2)'(dx) * (2*C+2)'(dby);
    end
    if (cmd.h_pop) begin
      top <= top - TW'(1);
      pb  <= pa;
    end
    if (cmd.h_popa) begin
      pa <= srd;
    end
    if (cmd.h_push) begin
      top <= top + TW'(1);
      pa  <= pb;
      pb  <= pp;
    end
    if (cmd.h_nextj) begin
      if (!phase) begin
        if (stat.j_last) begin
          phase <= 1'b1;
          lend  <= top + TW'(1);
          j     <= AW'(cnt - CW'(2));
        end else begin
          j <= j + AW'(1);
        end
      end else begin
        j <= j - AW'(1);
      end
    end
    if (cmd.e_rd0) begin
      k <= '0;
    end
    if (cmd.e_out) begin
      k <= k1;
    end
  end

endmodule

### sv/cvh_ctrl.sv
// cvh_ctrl: sequencer for sorted insertion, chain building and vertex output.
// depends on cvh_pkg.
module cvh_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  cvh_pkg::cvh_stat_t stat,
  output cvh_pkg::cvh_cmd_t  cmd,
  output logic               busy
);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_INS_CHK = 13'b0000000000010,
    S_INS_CMP = 13'b0000000000100,
    S_INS_PL  = 13'b0000000001000,
    S_H_START = 13'b0000000010000,
    S_H_RD    = 13'b0000000100000,
    S_H_FETCH = 13'b0000001000000,
    S_H_TEST  = 13'b0000010000000,
    S_H_CMP   = 13'b0000100000000,
    S_H_POPA  = 13'b0001000000000,
    S_H_PUSH  = 13'b0010000000000,
    S_E_START = 13'b0100000000000,
    S_E_OUT   = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.cap    = 1'b1;
          state_next = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (stat.full) begin
          cmd.set_ovf = 1'b1;
          state_next  = stat.fin ? S_H_START : S_IDLE;
        end else if (stat.cnt_zero) begin
          cmd.ins_place = 1'b1;
          state_next    = stat.fin ? S_H_START : S_IDLE;
        end else begin
          cmd.ins_rd = 1'b1;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat.less) begin
          cmd.ins_shift = 1'b1;
          if (stat.i_one) begin
            state_next = S_INS_PL;
          end
        end else begin
          cmd.ins_place = 1'b1;
          state_next    = stat.fin ? S_H_START : S_IDLE;
        end
      end
      S_INS_PL: begin
        cmd.ins_place = 1'b1;
        state_next    = stat.fin ? S_H_START : S_IDLE;
      end
      S_H_START: begin
        cmd.h_init = 1'b1;
        state_next = S_H_RD;
      end
      S_H_RD: begin
        state_next = S_H_FETCH;
      end
      S_H_FETCH: begin
        cmd.h_latch = 1'b1;
        state_next  = S_H_TEST;
      end
      S_H_TEST: begin
        if (stat.test_ok) begin
          cmd.h_mul  = 1'b1;
          state_next = S_H_CMP;
        end else begin
          state_next = S_H_PUSH;
        end
      end
      S_H_CMP: begin
        if (stat.left) begin
          cmd.h_pop  = 1'b1;
          state_next = stat.top_ge3 ? S_H_POPA : S_H_TEST;
        end else begin
          state_next = S_H_PUSH;
        end
      end
      S_H_POPA: begin
        cmd.h_popa = 1'b1;
        state_next = S_H_TEST;
      end
      S_H_PUSH: begin
        cmd.h_push = 1'b1;
        if (stat.j_last && (stat.phase_up || stat.n_one)) begin
          state_next = S_E_START;
        end else begin
          cmd.h_nextj = 1'b1;
          state_next  = S_H_RD;
        end
      end
      S_E_START: begin
        cmd.e_rd0  = 1'b1;
        state_next = S_E_OUT;
      end
      S_E_OUT: begin
        cmd.e_out = 1'b1;
        if (stat.e_last) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/convex_hull_monotone_chain.sv
// convex hull by monotone chain: a point item is inserted in sorted order, or dropped when
// the store is full, one store entry shifted per cycle; busy is high meanwhile.
// on the final item the hull pass builds both chains, popping as needed, then vertices leave
// one per cycle on strobe, which cannot be held off.
// synchronous reset returns to idle with an empty point set.
// depends on cvh_pkg, cvh_ctrl and cvh_datapath.
module convex_hull_monotone_chain #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] px,
  input  logic [COORD_BITS-1:0] py,
  input  logic                  final_point,
  output logic                  strobe,
  output logic [COORD_BITS-1:0] hx,
  output logic [COORD_BITS-1:0] hy,
  output logic                  last_vertex,
  output logic                  points_dropped
);

  cvh_pkg::cvh_cmd_t  cmd;
  cvh_pkg::cvh_stat_t stat;

  cvh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
  );

  cvh_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .rst(rst), .px(px), .py(py), .final_point(final_point),
    .cmd(cmd), .stat(stat), .hx(hx), .hy(hy), .dropped(points_dropped)
  );

  assign strobe      = cmd.e_out;
  assign last_vertex = cmd.e_out & stat.e_last;

endmodule

### sv/cvh_checker.sv
// cvh_checker: port-level checks for convex_hull_monotone_chain, with bind.
// depends on convex_hull_monotone_chain.
module cvh_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic strobe,
  input logic last_vertex
);

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("result outside busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted item without busy");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_vertex) |=> strobe) else $error("vertex burst broken");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_vertex) |=> !busy) else $error("busy after last vertex");

endmodule

bind convex_hull_monotone_chain cvh_checker u_cvh_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe),
  .last_vertex(last_vertex)
);
